### src/dtep_pkg.sv
// Package for the date-time to epoch seconds converter: widths, calendar
// constants, month tables and the check result record.
// No dependencies.
package dtep_pkg;

  // Field widths
  localparam int YEAR_W  = 14;
  localparam int FIELD_W = 7;
  localparam int DAYS_W  = 22;
  localparam int SECS_W  = 38;
  localparam int WDAY_W  = 3;
  localparam int TOD_W   = 17;
  localparam int DOY_W   = 9;
  localparam int Q100_W  = 7;
  localparam int MLEN_W  = 5;
  localparam int MONTH_W = 4;

  // Calendar constants
  localparam int EPOCH_YEAR   = 1900;
  localparam int MAX_YEAR     = 9999;
  localparam int SECS_PER_DAY = 86400;
  localparam int SECS_PER_HR  = 3600;
  localparam int SECS_PER_MIN = 60;
  localparam int HOURS_PER_DAY = 24;
  localparam int MINS_PER_HR  = 60;
  localparam int DAYS_PER_YR  = 365;
  localparam int MONTHS       = 12;
  localparam int FEB          = 2;

  // Days from 1 Jan of year 1 to 1 Jan of the epoch year
  localparam int EPOCH_P   = EPOCH_YEAR - 1;
  localparam int EPOCH_ABS = DAYS_PER_YR * EPOCH_P + EPOCH_P / 4 - EPOCH_P / 100
                             + EPOCH_P / 400;

  // floor(x / 100) = (x * RECIP100) >> RECIP100_SH, exact for x below 43699
  localparam int RECIP100    = 5243;
  localparam int RECIP100_SH = 19;
  localparam int RECIP100_W  = 13;
  localparam int QPROD_W     = YEAR_W + RECIP100_W;

  // x divisible by 25 iff (x * INV25) mod 2^12 <= DIV25_LIM, for 12-bit x
  localparam int Y4_W      = YEAR_W - 2;
  localparam int INV25     = 3113;
  localparam int DIV25_LIM = 163;

  // Result of the field checks and decoding, held in stage 2 of the conversion
  typedef struct packed {
    logic                ok;
    logic [YEAR_W-1:0]   p;     // year - 1
    logic [Q100_W-1:0]   q100;  // (year - 1) / 100
    logic [DOY_W-1:0]    doy;   // day of year, from 0
    logic [TOD_W-1:0]    tod;   // seconds since midnight
  } info_t;

  // Length of month m (1..12), February 29 days when leap is set; 0 for other m
  function automatic logic [MLEN_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [MLEN_W-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = MLEN_W'(31);
      4'd4, 4'd6, 4'd9, 4'd11:                    len = MLEN_W'(30);
      4'd2:                                       len = leap ? MLEN_W'(29)
                                                             : MLEN_W'(28);
      default:                                    len = '0;
    endcase
    return len;
  endfunction

  // Days in a common year before the first of month m
  function automatic logic [DOY_W-1:0] month_cum(input logic [MONTH_W-1:0] m);
    logic [DOY_W-1:0] cum;
    case (m)
      4'd1:    cum = DOY_W'(0);
      4'd2:    cum = DOY_W'(31);
      4'd3:    cum = DOY_W'(59);
      4'd4:    cum = DOY_W'(90);
      4'd5:    cum = DOY_W'(120);
      4'd6:    cum = DOY_W'(151);
      4'd7:    cum = DOY_W'(181);
      4'd8:    cum = DOY_W'(212);
      4'd9:    cum = DOY_W'(243);
      4'd10:   cum = DOY_W'(273);
      4'd11:   cum = DOY_W'(304);
      4'd12:   cum = DOY_W'(334);
      default: cum = '0;
    endcase
    return cum;
  endfunction

endpackage

### src/dtep_check.sv
// Field checks, leap year, day of year and time of day for one item.
// Depends on dtep_pkg.
module dtep_check (
  input  logic [dtep_pkg::YEAR_W-1:0]  year,
  input  logic [dtep_pkg::FIELD_W-1:0] month,
  input  logic [dtep_pkg::FIELD_W-1:0] day,
  input  logic [dtep_pkg::FIELD_W-1:0] hour,
  input  logic [dtep_pkg::FIELD_W-1:0] minute,
  input  logic [dtep_pkg::FIELD_W-1:0] second,
  output dtep_pkg::info_t              info
);

  logic                              year_ok;
  logic                              month_ok;
  logic                              day_ok;
  logic                              time_ok;
  logic [dtep_pkg::MONTH_W-1:0]      m4;
  logic [2*dtep_pkg::Y4_W-1:0]       prod25;
  logic                              div25;
  logic                              leap;
  logic [dtep_pkg::MLEN_W-1:0]       mlen;
  logic [dtep_pkg::YEAR_W-1:0]       p;
  logic [dtep_pkg::QPROD_W-1:0]      qprod;
  logic                              feb_adj;

  assign year_ok  = (year >= dtep_pkg::YEAR_W'(dtep_pkg::EPOCH_YEAR)) &&
                    (year <= dtep_pkg::YEAR_W'(dtep_pkg::MAX_YEAR));
  assign month_ok = (month >= dtep_pkg::FIELD_W'(1)) &&
                    (month <= dtep_pkg::FIELD_W'(dtep_pkg::MONTHS));
  assign m4       = month[dtep_pkg::MONTH_W-1:0];

  // year/4 divisible by 25 via the modular inverse; leap needs year%4 == 0
  assign prod25 = (2*dtep_pkg::Y4_W)'(year[dtep_pkg::YEAR_W-1:2]) *
                  (2*dtep_pkg::Y4_W)'(dtep_pkg::INV25);
  assign div25  = prod25[dtep_pkg::Y4_W-1:0] <= dtep_pkg::Y4_W'(dtep_pkg::DIV25_LIM);
  assign leap   = (year[1:0] == 2'b00) && (!div25 || (year[3:0] == 4'b0000));

  assign mlen   = month_ok ? dtep_pkg::month_len(m4, leap) : '0;
  assign day_ok = (day >= dtep_pkg::FIELD_W'(1)) &&
                  (day <= dtep_pkg::FIELD_W'(mlen));
  assign time_ok = (hour   < dtep_pkg::FIELD_W'(dtep_pkg::HOURS_PER_DAY)) &&
                   (minute < dtep_pkg::FIELD_W'(dtep_pkg::MINS_PER_HR)) &&
                   (second < dtep_pkg::FIELD_W'(dtep_pkg::MINS_PER_HR));

  assign p     = year - dtep_pkg::YEAR_W'(1);
  assign qprod = dtep_pkg::QPROD_W'(p) * dtep_pkg::QPROD_W'(dtep_pkg::RECIP100);

  assign feb_adj = leap && (m4 > dtep_pkg::MONTH_W'(dtep_pkg::FEB));

  always_comb begin
    info.ok   = year_ok && month_ok && day_ok && time_ok;
    info.p    = p;
    info.q100 = qprod[dtep_pkg::RECIP100_SH +: dtep_pkg::Q100_W];
    info.doy  = dtep_pkg::month_cum(m4) + dtep_pkg::DOY_W'(feb_adj) +
                dtep_pkg::DOY_W'(day) - dtep_pkg::DOY_W'(1);
    info.tod  = dtep_pkg::TOD_W'(hour)   * dtep_pkg::TOD_W'(dtep_pkg::SECS_PER_HR) +
                dtep_pkg::TOD_W'(minute) * dtep_pkg::TOD_W'(dtep_pkg::SECS_PER_MIN) +
                dtep_pkg::TOD_W'(second);
  end

endmodule

### src/datetime_to_epoch_seconds.sv
// Gregorian date and time to days, seconds and ISO weekday since the epoch year.
// Throughput: one item per cycle; four register stages, each holding on a stall.
// Input register, then checked and decoded fields, then day counts, then the output
// register with the seconds product and weekday. rst_n (synchronous, active low)
// empties all stages. Depends on dtep_pkg and dtep_check.
module datetime_to_epoch_seconds (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [dtep_pkg::YEAR_W-1:0]   in_year_in,
  input  logic [dtep_pkg::FIELD_W-1:0]  in_month_in,
  input  logic [dtep_pkg::FIELD_W-1:0]  in_day_in,
  input  logic [dtep_pkg::FIELD_W-1:0]  in_hour_in,
  input  logic [dtep_pkg::FIELD_W-1:0]  in_minute_in,
  input  logic [dtep_pkg::FIELD_W-1:0]  in_second_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_is_valid,
  output logic [dtep_pkg::DAYS_W-1:0]   out_days_since_epoch,
  output logic [dtep_pkg::SECS_W-1:0]   out_seconds_since_epoch,
  output logic [dtep_pkg::WDAY_W-1:0]   out_weekday
);

  // Stage valid flags and per-stage advance enables
  logic v1_r, v2_r, v3_r, v4_r;
  logic en1, en2, en3, en4;

  // Stage 1: registered input item
  logic [dtep_pkg::YEAR_W-1:0]  year_r;
  logic [dtep_pkg::FIELD_W-1:0] month_r, day_r, hour_r, minute_r, second_r;

  // Stage 2: checked and decoded item
  dtep_pkg::info_t info_nxt, info_r;

  // Stage 3: day counts
  logic                         ok3_r;
  logic [dtep_pkg::DAYS_W-1:0]  abs_nxt, abs_r;
  logic [dtep_pkg::DAYS_W-1:0]  days_nxt, days_r;
  logic [dtep_pkg::TOD_W-1:0]   tod3_r;

  // Output stage
  logic [dtep_pkg::SECS_W-1:0]  secs_nxt;
  logic [5:0]                   oct_sum;
  logic [3:0]                   fold;
  logic [2:0]                   rem7;
  logic                         ok_out_r;
  logic [dtep_pkg::DAYS_W-1:0]  days_out_r;
  logic [dtep_pkg::SECS_W-1:0]  secs_out_r;
  logic [dtep_pkg::WDAY_W-1:0]  wday_out_r;

  // A stage takes a new item when it is empty or its contents move on
  assign en4      = !v4_r || out_ready;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  // Field checks, leap year, day of year and time of day
  dtep_check u_check (
    .year   (year_r),
    .month  (month_r),
    .day    (day_r),
    .hour   (hour_r),
    .minute (minute_r),
    .second (second_r),
    .info   (info_nxt)
  );

  // Closed-form leap count: 365p + p/4 - p/100 + p/400, with p = year - 1
  assign abs_nxt = dtep_pkg::DAYS_W'(info_r.p) * dtep_pkg::DAYS_W'(dtep_pkg::DAYS_PER_YR) +
                   dtep_pkg::DAYS_W'(info_r.p >> 2) -
                   dtep_pkg::DAYS_W'(info_r.q100) +
                   dtep_pkg::DAYS_W'(info_r.q100 >> 2) +
                   dtep_pkg::DAYS_W'(info_r.doy);
  assign days_nxt = abs_nxt - dtep_pkg::DAYS_W'(dtep_pkg::EPOCH_ABS);

  assign secs_nxt = dtep_pkg::SECS_W'(days_r) * dtep_pkg::SECS_W'(dtep_pkg::SECS_PER_DAY) +
                    dtep_pkg::SECS_W'(tod3_r);

  // Day 0 (1 Jan of year 1) is a Monday. Reduce mod 7 by summing octal digits,
  // since 8 is 1 mod 7.
  always_comb begin
    logic [23:0] abs_pad;
    abs_pad = 24'(abs_r);
    oct_sum = '0;
    for (int i = 0; i < 8; i++) begin
      oct_sum = oct_sum + 6'(abs_pad[3*i +: 3]);
    end
    fold = 4'(oct_sum[5:3]) + 4'(oct_sum[2:0]);
    if (fold >= 4'd14)     rem7 = 3'(fold - 4'd14);
    else if (fold >= 4'd7) rem7 = 3'(fold - 4'd7);
    else                   rem7 = fold[2:0];
  end

  // Payload registers: hold while the stage is stalled
  always_ff @(posedge clk) begin
    if (en1) begin
      year_r   <= in_year_in;
      month_r  <= in_month_in;
      day_r    <= in_day_in;
      hour_r   <= in_hour_in;
      minute_r <= in_minute_in;
      second_r <= in_second_in;
    end
    if (en2) begin
      info_r <= info_nxt;
    end
    if (en3) begin
      ok3_r  <= info_r.ok;
      abs_r  <= abs_nxt;
      days_r <= days_nxt;
      tod3_r <= info_r.tod;
    end
  end

  // Output register; an invalid item gives all-zero results
  always_ff @(posedge clk) begin
    if (en4) begin
      ok_out_r   <= ok3_r;
      days_out_r <= ok3_r ? days_r : '0;
      secs_out_r <= ok3_r ? secs_nxt : '0;
      wday_out_r <= ok3_r ? (rem7 + 3'd1) : '0;
    end
  end

  // The output register is a stage of its own, tracked by v4_r
  assign out_valid               = v4_r;
  assign out_is_valid            = ok_out_r;
  assign out_days_since_epoch    = days_out_r;
  assign out_seconds_since_epoch = secs_out_r;
  assign out_weekday             = wday_out_r;

endmodule
